// ===== sv/point_attractor_velocity_update_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef POINT_ATTRACTOR_VELOCITY_UPDATE_MACROS_SVH
`define POINT_ATTRACTOR_VELOCITY_UPDATE_MACROS_SVH

// Same-cycle implication, off while in reset.
`define PAV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset.
`define PAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pav_pkg.sv =====
package pav_pkg;

   localparam int unsigned COORD_W     = 32;
   localparam int unsigned MAG_W       = 32;
   localparam int unsigned TS_W        = 24;
   localparam int unsigned MD_W        = 31;
   localparam int unsigned SQ_W        = 66;
   localparam int unsigned ROOT_W      = 33;
   localparam int unsigned DEN_W       = 2 * ROOT_W;
   localparam int unsigned NUM_W       = 87;
   localparam int unsigned QBITS       = 42;
   localparam int unsigned CAP_EXP     = 40;
   localparam int unsigned CSR_IDX_W   = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [COORD_W-1:0] STRENGTH_RST = 32'd65536;
   localparam logic [MD_W-1:0]    MIN_DIST_RST = 31'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_ORIGIN_Z  = 3'd2,
      CSR_STRENGTH  = 3'd3,
      CSR_MIN_DIST  = 3'd4,
      CSR_TIME_STEP = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [2:0][COORD_W-1:0] origin;
      logic [COORD_W-1:0]      strength;
      logic [MD_W-1:0]         min_dist;
      logic [TS_W-1:0]         time_step;
   } cfg_type;

   // Per-item payload that rides along the back pipeline.
   typedef struct packed {
      logic [2:0]              dneg;
      logic [2:0][COORD_W-1:0] vel;
      logic                    alive;
   } pay_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      pay_type               pay;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== sv/pav_if.sv =====
interface pav_req_if;
   import pav_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pos_x;
   logic [COORD_W-1:0] pos_y;
   logic [COORD_W-1:0] pos_z;
   logic [COORD_W-1:0] vel_x;
   logic [COORD_W-1:0] vel_y;
   logic [COORD_W-1:0] vel_z;
   logic               alive;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, alive,
                   input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, alive,
                   output ready);
endinterface

interface pav_rsp_if;
   import pav_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] new_vel_x;
   logic [COORD_W-1:0] new_vel_y;
   logic [COORD_W-1:0] new_vel_z;
   logic               saturated;
   modport source (output valid, new_vel_x, new_vel_y, new_vel_z, saturated,
                   input ready);
   modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, saturated,
                   output ready);
endinterface

// ===== sv/pav_front.sv =====
module pav_front (
   input  logic              clock,
   input  logic              reset,
   input  pav_pkg::cfg_type  cfg,
   pav_req_if.sink           req_chan,
   input  logic              push_ready,
   output logic              item_valid,
   output pav_pkg::item_type item
);
   import pav_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;
   logic [2:0][COORD_W-1:0] pos;
   logic [COORD_W:0]        d;

   assign req_chan.ready = !valid_ff || push_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign pos            = {req_chan.pos_z, req_chan.pos_y, req_chan.pos_x};

   always_comb begin
      item_in           = item_ff;
      item_in.pay.vel   = {req_chan.vel_z, req_chan.vel_y, req_chan.vel_x};
      item_in.pay.alive = req_chan.alive;
      for (int c = 0; c < 3; c++) begin
         d = {cfg.origin[c][COORD_W-1], cfg.origin[c]} - {pos[c][COORD_W-1], pos[c]};
         item_in.pay.dneg[c] = d[COORD_W];
         item_in.mag[c]      = d[COORD_W] ? MAG_W'(-d) : d[MAG_W-1:0];
      end
      valid_in = take || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/pav_queue.sv =====
module pav_queue #(
   parameter int unsigned DEPTH = pav_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  pav_pkg::item_type     push_item,
   input  logic                  pop,
   output pav_pkg::q_status_type status,
   output pav_pkg::item_type     head
);
   import pav_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pull;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign push         = push_valid && !status.full;
   assign pull         = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pull) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pull);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/pav_back.sv =====
module pav_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pav_pkg::cfg_type      cfg,
   input  pav_pkg::q_status_type q_status,
   input  pav_pkg::item_type     head,
   output logic                  pop,
   pav_rsp_if.source             rsp_chan
);
   import pav_pkg::*;

   localparam int unsigned M2_W  = 2 * MAG_W;
   localparam int unsigned MT_W  = MAG_W + TS_W;
   localparam int unsigned LO_W  = MT_W / 2;
   localparam int unsigned HI_W  = MT_W - LO_W;
   localparam int unsigned PLO_W = LO_W + COORD_W;
   localparam int unsigned PHI_W = HI_W + COORD_W;
   localparam int unsigned REM_W = ROOT_W + 3;
   localparam int unsigned RAD_W = 2 * ROOT_W;
   localparam int unsigned CMP_W = DEN_W + QBITS;
   localparam int unsigned SUM_W = QBITS + 1;

   logic en;

   // multiply stage one: squares and |d|*time_step
   logic                  s1_v_ff, s1_v_in;
   logic [2:0][M2_W-1:0]  s1_m2_ff, s1_m2_in;
   logic [2:0][MT_W-1:0]  s1_mt_ff, s1_mt_in;
   pay_type               s1_pay_ff;
   // multiply stage two: sum of squares, partial products with |strength|
   logic                  s2_v_ff;
   logic [SQ_W-1:0]       s2_sq_ff, s2_sq_in;
   logic [2:0][PLO_W-1:0] s2_plo_ff, s2_plo_in;
   logic [2:0][PHI_W-1:0] s2_phi_ff, s2_phi_in;
   pay_type               s2_pay_ff;
   logic [COORD_W-1:0]    smag;
   // square root, one result bit per stage
   logic                    rt_v_ff    [ROOT_W+1];
   logic [REM_W-1:0]        rt_rem_ff  [ROOT_W+1];
   logic [REM_W-1:0]        rt_rem_in  [ROOT_W+1];
   logic [ROOT_W-1:0]       rt_root_ff [ROOT_W+1];
   logic [ROOT_W-1:0]       rt_root_in [ROOT_W+1];
   logic [RAD_W-1:0]        rt_rad_ff  [ROOT_W+1];
   logic [RAD_W-1:0]        rt_rad_in  [ROOT_W+1];
   logic [2:0][NUM_W-1:0]   rt_num_ff  [ROOT_W+1];
   logic [2:0][NUM_W-1:0]   rt_num_in  [ROOT_W+1];
   pay_type                 rt_pay_ff  [ROOT_W+1];
   logic [REM_W-1:0]        rem_sh, trial;
   // separation floor
   logic                    sp_v_ff;
   logic [ROOT_W-1:0]       sp_sep_ff, sp_sep_in;
   logic [2:0][NUM_W-1:0]   sp_num_ff;
   pay_type                 sp_pay_ff;
   // long division, one quotient bit per stage
   logic                    dv_v_ff    [QBITS+1];
   logic [DEN_W-1:0]        dv_den_ff  [QBITS+1];
   logic [DEN_W-1:0]        dv_den_in  [QBITS+1];
   logic [2:0][NUM_W-1:0]   dv_rem_ff  [QBITS+1];
   logic [2:0][NUM_W-1:0]   dv_rem_in  [QBITS+1];
   logic [2:0][QBITS-1:0]   dv_q_ff    [QBITS+1];
   logic [2:0][QBITS-1:0]   dv_q_in    [QBITS+1];
   logic [2:0]              dv_over_ff [QBITS+1];
   logic [2:0]              dv_over_in [QBITS+1];
   pay_type                 dv_pay_ff  [QBITS+1];
   logic [CMP_W-1:0]        shifted, rem_w;
   // output register
   logic                    rsp_v_ff, rsp_v_in;
   logic [2:0][COORD_W-1:0] rsp_vel_ff, rsp_vel_in;
   logic                    rsp_sat_ff, rsp_sat_in;
   logic [QBITS-1:0]        q, qcap;
   logic signed [SUM_W-1:0] sdelta, nv;
   logic                    neg, sat_hi, sat_lo;

   // Whole back pipeline advances together; stall only on a full output.
   assign en      = !rsp_v_ff || rsp_chan.ready;
   assign pop     = en && !q_status.empty;
   assign s1_v_in = !q_status.empty;
   assign smag    = cfg.strength[COORD_W-1] ? (~cfg.strength + 1'b1) : cfg.strength;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s1_m2_in[c]  = M2_W'(head.mag[c]) * M2_W'(head.mag[c]);
         s1_mt_in[c]  = MT_W'(head.mag[c]) * MT_W'(cfg.time_step);
         s2_plo_in[c] = PLO_W'(s1_mt_ff[c][LO_W-1:0]) * PLO_W'(smag);
         s2_phi_in[c] = PHI_W'(s1_mt_ff[c][MT_W-1:LO_W]) * PHI_W'(smag);
      end
      s2_sq_in = SQ_W'(s1_m2_ff[0]) + SQ_W'(s1_m2_ff[1]) + SQ_W'(s1_m2_ff[2]);
   end

   // Square root: digit-by-digit, two radicand bits per stage.
   always_comb begin
      rem_sh        = '0;
      trial         = '0;
      rt_rem_in[0]  = '0;
      rt_root_in[0] = '0;
      rt_rad_in[0]  = RAD_W'(s2_sq_ff);
      for (int c = 0; c < 3; c++) begin
         rt_num_in[0][c] = NUM_W'({s2_phi_ff[c], LO_W'(0)}) + NUM_W'(s2_plo_ff[c]);
      end
      for (int k = 0; k < ROOT_W; k++) begin
         rem_sh = {rt_rem_ff[k][REM_W-3:0], rt_rad_ff[k][RAD_W-1 -: 2]};
         trial  = {1'b0, rt_root_ff[k], 2'b01};
         if (rem_sh >= trial) begin
            rt_rem_in[k+1]  = rem_sh - trial;
            rt_root_in[k+1] = {rt_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            rt_rem_in[k+1]  = rem_sh;
            rt_root_in[k+1] = {rt_root_ff[k][ROOT_W-2:0], 1'b0};
         end
         rt_rad_in[k+1] = {rt_rad_ff[k][RAD_W-3:0], 2'b00};
         rt_num_in[k+1] = rt_num_ff[k];
      end
   end

   always_comb begin
      if (rt_root_ff[ROOT_W] < ROOT_W'(cfg.min_dist)) begin
         sp_sep_in = ROOT_W'(cfg.min_dist);
      end else begin
         sp_sep_in = rt_root_ff[ROOT_W];
      end
   end

   // Division: restoring, quotient bit QBITS-1 first; overflow flagged up front.
   always_comb begin
      shifted       = '0;
      rem_w         = '0;
      dv_den_in[0]  = DEN_W'(sp_sep_ff) * DEN_W'(sp_sep_ff);
      dv_rem_in[0]  = sp_num_ff;
      dv_q_in[0]    = '0;
      dv_over_in[0] = '0;
      for (int j = 0; j < QBITS; j++) begin
         dv_den_in[j+1]  = dv_den_ff[j];
         dv_rem_in[j+1]  = dv_rem_ff[j];
         dv_q_in[j+1]    = dv_q_ff[j];
         dv_over_in[j+1] = dv_over_ff[j];
         for (int c = 0; c < 3; c++) begin
            rem_w   = CMP_W'(dv_rem_ff[j][c]);
            shifted = CMP_W'(dv_den_ff[j]) << (QBITS - 1 - j);
            if (j == 0) begin
               dv_over_in[j+1][c] = rem_w >= (CMP_W'(dv_den_ff[j]) << QBITS);
            end
            if (rem_w >= shifted) begin
               dv_rem_in[j+1][c] = NUM_W'(rem_w - shifted);
               dv_q_in[j+1][c][QBITS-1-j] = 1'b1;
            end
         end
      end
   end

   // Cap the quotient, apply sign, add to velocity, clip to the 32-bit range.
   always_comb begin
      q          = '0;
      qcap       = '0;
      sdelta     = '0;
      nv         = '0;
      neg        = 1'b0;
      sat_hi     = 1'b0;
      sat_lo     = 1'b0;
      rsp_v_in   = dv_v_ff[QBITS];
      rsp_vel_in = dv_pay_ff[QBITS].vel;
      rsp_sat_in = 1'b0;
      if (dv_pay_ff[QBITS].alive && (dv_den_ff[QBITS] != '0)) begin
         for (int c = 0; c < 3; c++) begin
            q    = dv_q_ff[QBITS][c];
            qcap = (dv_over_ff[QBITS][c] || q > (QBITS'(1) << CAP_EXP))
                   ? (QBITS'(1) << CAP_EXP) : q;
            neg    = dv_pay_ff[QBITS].dneg[c] ^ cfg.strength[COORD_W-1];
            sdelta = neg ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});
            nv     = $signed({{(SUM_W-COORD_W){dv_pay_ff[QBITS].vel[c][COORD_W-1]}},
                              dv_pay_ff[QBITS].vel[c]}) + sdelta;
            sat_hi = !nv[SUM_W-1] && (nv[SUM_W-2:COORD_W-1] != '0);
            sat_lo =  nv[SUM_W-1] && (nv[SUM_W-2:COORD_W-1] != '1);
            if (sat_hi) begin
               rsp_vel_in[c] = {1'b0, {(COORD_W-1){1'b1}}};
            end else if (sat_lo) begin
               rsp_vel_in[c] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
               rsp_vel_in[c] = nv[COORD_W-1:0];
            end
            rsp_sat_in = rsp_sat_in || sat_hi || sat_lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         sp_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         for (int k = 0; k <= ROOT_W; k++) begin
            rt_v_ff[k] <= 1'b0;
         end
         for (int j = 0; j <= QBITS; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else if (en) begin
         s1_v_ff    <= s1_v_in;
         s2_v_ff    <= s1_v_ff;
         rt_v_ff[0] <= s2_v_ff;
         for (int k = 1; k <= ROOT_W; k++) begin
            rt_v_ff[k] <= rt_v_ff[k-1];
         end
         sp_v_ff    <= rt_v_ff[ROOT_W];
         dv_v_ff[0] <= sp_v_ff;
         for (int j = 1; j <= QBITS; j++) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_m2_ff     <= s1_m2_in;
         s1_mt_ff     <= s1_mt_in;
         s1_pay_ff    <= head.pay;
         s2_sq_ff     <= s2_sq_in;
         s2_plo_ff    <= s2_plo_in;
         s2_phi_ff    <= s2_phi_in;
         s2_pay_ff    <= s1_pay_ff;
         rt_pay_ff[0] <= s2_pay_ff;
         for (int k = 0; k <= ROOT_W; k++) begin
            rt_rem_ff[k]  <= rt_rem_in[k];
            rt_root_ff[k] <= rt_root_in[k];
            rt_rad_ff[k]  <= rt_rad_in[k];
            rt_num_ff[k]  <= rt_num_in[k];
         end
         for (int k = 1; k <= ROOT_W; k++) begin
            rt_pay_ff[k] <= rt_pay_ff[k-1];
         end
         sp_sep_ff    <= sp_sep_in;
         sp_num_ff    <= rt_num_ff[ROOT_W];
         sp_pay_ff    <= rt_pay_ff[ROOT_W];
         dv_pay_ff[0] <= sp_pay_ff;
         for (int j = 0; j <= QBITS; j++) begin
            dv_den_ff[j]  <= dv_den_in[j];
            dv_rem_ff[j]  <= dv_rem_in[j];
            dv_q_ff[j]    <= dv_q_in[j];
            dv_over_ff[j] <= dv_over_in[j];
         end
         for (int j = 1; j <= QBITS; j++) begin
            dv_pay_ff[j] <= dv_pay_ff[j-1];
         end
         rsp_vel_ff <= rsp_vel_in;
         rsp_sat_ff <= rsp_sat_in;
      end
   end

   assign rsp_chan.valid     = rsp_v_ff;
   assign rsp_chan.new_vel_x = rsp_vel_ff[0];
   assign rsp_chan.new_vel_y = rsp_vel_ff[1];
   assign rsp_chan.new_vel_z = rsp_vel_ff[2];
   assign rsp_chan.saturated = rsp_sat_ff;

endmodule

// ===== sv/point_attractor_velocity_update.sv =====
// Point attractor velocity update: one particle in, one updated velocity out.
// req_chan carries position, velocity and the alive flag of one particle; an
// item moves on a clock edge with valid and ready both high. rsp_chan returns
// the new velocity and a flag that is high when a component was clipped.
// csr_* writes the attractor origin, strength, minimum distance and time step;
// write them only while no item is in flight.
// Throughput: one item per cycle while rsp_chan is not stalled, with no
// dependence between items. Most of the path from the accepting edge to
// rsp_chan.valid is the 33-stage square root (one root bit per stage) and
// the 42-stage divider (one quotient bit per stage, three lanes side by side).
// The front stage registers the particle and its offset from the origin, then
// hands it through a small queue to the back pipeline, so req_chan keeps
// taking items while rsp_chan is stalled until the queue and front stage fill.
// When the receiver stalls, the whole back pipeline holds and the queue fills;
// req_chan.ready drops once the queue and front stage are full.
// Reset clears all valid bits and loads the register defaults: origin zero,
// strength 65536, minimum distance 65536, time step zero.
module point_attractor_velocity_update #(
   parameter int unsigned QUEUE_DEPTH = pav_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   pav_req_if.sink                          req_chan,
   pav_rsp_if.source                        rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [pav_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pav_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import pav_pkg::*;
   `include "point_attractor_velocity_update_macros.svh"

   cfg_type      cfg_ff, cfg_in;
   logic         front_valid;
   item_type     front_item;
   q_status_type q_stat;
   item_type     q_head;
   logic         q_pop;

   // Register file: decode the index, drop writes beyond the list.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ORIGIN_X:  cfg_in.origin[0] = csr_wr_data;
            CSR_ORIGIN_Y:  cfg_in.origin[1] = csr_wr_data;
            CSR_ORIGIN_Z:  cfg_in.origin[2] = csr_wr_data;
            CSR_STRENGTH:  cfg_in.strength  = csr_wr_data;
            CSR_MIN_DIST:  cfg_in.min_dist  = csr_wr_data[MD_W-1:0];
            CSR_TIME_STEP: cfg_in.time_step = csr_wr_data[TS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{origin: '0, strength: STRENGTH_RST, min_dist: MIN_DIST_RST,
                     time_step: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take the particle, form |origin - pos| and its sign.
   pav_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_ready (!q_stat.full),
      .item_valid (front_valid),
      .item       (front_item)
   );

   // Decouple front and back so each side stalls on its own.
   pav_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .pop        (q_pop),
      .status     (q_stat),
      .head       (q_head)
   );

   // Back: distance, root, divide, add and clip.
   pav_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_status (q_stat),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

   `PAV_ASSERT_SAME(a_reset_clears_rsp, clock, reset, $past(reset), !rsp_chan.valid, "rsp valid right after reset")
   `PAV_ASSERT_SAME(a_pop_nonempty, clock, reset, q_pop, !q_stat.empty, "pop from an empty queue")
   `PAV_ASSERT_NEXT(a_ts_write, clock, reset, csr_wr_en && (csr_index == CSR_TIME_STEP), cfg_ff.time_step == $past(csr_wr_data[TS_W-1:0]), "time step write lost")

endmodule
